// ----- hw/rtl/atb_pkg.sv -----
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants of the task-file command builder
// request and result structs, register codes, command bytes, error codes
// ----------------------------------------------------------------------------
`default_nettype none

package atb_pkg;

	localparam int ATB_LBA_W  = 48;
	localparam int ATB_CNT_W  = 16;
	localparam int ATB_GEO_W  = 16;
	localparam int ATB_CFG_W  = 48;
	localparam int ATB_IDX_W  = 3;
	localparam int ATB_DIV_STEPS = 2;

	// configuration register indexes
	localparam logic [ATB_IDX_W-1:0] CFG_MODE  = 3'd0;
	localparam logic [ATB_IDX_W-1:0] CFG_TOTAL = 3'd1;
	localparam logic [ATB_IDX_W-1:0] CFG_MAXS  = 3'd2;
	localparam logic [ATB_IDX_W-1:0] CFG_SPT   = 3'd3;
	localparam logic [ATB_IDX_W-1:0] CFG_HEADS = 3'd4;

	// addressing capability
	localparam logic [1:0] MODE_CHS   = 2'd0;
	localparam logic [1:0] MODE_LBA48 = 2'd2;

	// task-file registers
	localparam logic [4:0] REG_COUNT = 5'h12;
	localparam logic [4:0] REG_LBA0  = 5'h13;
	localparam logic [4:0] REG_LBA1  = 5'h14;
	localparam logic [4:0] REG_LBA2  = 5'h15;
	localparam logic [4:0] REG_SEL   = 5'h16;
	localparam logic [4:0] REG_CMD   = 5'h17;

	// command bytes
	localparam logic [7:0] CMD_RD_MULT     = 8'hC4;
	localparam logic [7:0] CMD_RD_SECT     = 8'h21;
	localparam logic [7:0] CMD_RD_MULT_EXT = 8'h29;
	localparam logic [7:0] CMD_RD_SECT_EXT = 8'h24;
	localparam logic [7:0] CMD_WR_MULT     = 8'hC5;
	localparam logic [7:0] CMD_WR_SECT     = 8'h30;
	localparam logic [7:0] CMD_WR_MULT_EXT = 8'h39;
	localparam logic [7:0] CMD_WR_SECT_EXT = 8'h34;

	localparam logic [7:0] SEL_LBA48 = 8'h40;
	localparam logic [7:0] SEL_LBA28 = 8'hE0;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MULTIPLE = 3'd1;
	localparam logic [2:0] ERR_PAST_END = 3'd2;
	localparam logic [2:0] ERR_NO_LBA48 = 3'd3;
	localparam logic [2:0] ERR_COUNT    = 3'd4;

	localparam logic [ATB_LBA_W:0] LBA28_LIMIT = (ATB_LBA_W+1)'(1) << 28;

	typedef struct packed {
		logic                 func;
		logic [ATB_LBA_W-1:0] start_sector;
		logic [ATB_CNT_W-1:0] sector_count;
	} atb_in_t;

	typedef struct packed {
		logic [4:0] reg_addr;
		logic [7:0] reg_value;
		logic [2:0] error_code;
		logic       last;
	} atb_out_t;

	// checked request as it travels down the pipeline
	typedef struct packed {
		logic                 func;
		logic [ATB_LBA_W-1:0] start_sector;
		logic [ATB_CNT_W-1:0] sector_count;
		logic [2:0]           err;
		logic                 big;
		logic                 lba;
	} atb_item_t;

	typedef struct packed {
		atb_item_t            item;
		logic [ATB_GEO_W-1:0] sect_rem;
	} atb_div2_tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/atb_div.sv -----
// ----------------------------------------------------------------------------
// atb_div: pipelined restoring divider
// SPS quotient bits per stage, side tag travels with each dividend
// ----------------------------------------------------------------------------
`default_nettype none

module atb_div
	import atb_pkg::*;
#(
	parameter int W   = ATB_LBA_W,
	parameter int DW  = ATB_GEO_W,
	parameter int SPS = ATB_DIV_STEPS,
	parameter int TW  = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [W-1:0]  dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [TW-1:0] in_tag,
	output logic               out_vld,
	output logic [W-1:0]       quot,
	output logic [DW-1:0]      rem,
	output logic [TW-1:0]      out_tag
);

	localparam int NST = (W + SPS - 1) / SPS;

	logic          v_s   [NST];
	logic [DW-1:0] rem_s [NST];
	logic [W-1:0]  dq_s  [NST];
	logic [TW-1:0] tag_s [NST];

	logic          vin  [NST];
	logic [DW-1:0] rin  [NST];
	logic [W-1:0]  qin  [NST];
	logic [TW-1:0] tin  [NST];
	logic [DW-1:0] rnx  [NST];
	logic [W-1:0]  qnx  [NST];

	always_comb begin
		vin[0] = in_vld;
		rin[0] = '0;
		qin[0] = dividend;
		tin[0] = in_tag;
		for (int s = 1; s < NST; s++) begin
			vin[s] = v_s[s-1];
			rin[s] = rem_s[s-1];
			qin[s] = dq_s[s-1];
			tin[s] = tag_s[s-1];
		end
	end

	// one quotient bit per step: remainder shifts in the next dividend bit
	always_comb begin
		logic [DW-1:0] r;
		logic [W-1:0]  q;
		logic [DW:0]   t;
		logic [DW:0]   d;
		logic          ge;
		d = {1'b0, divisor};
		for (int s = 0; s < NST; s++) begin
			r = rin[s];
			q = qin[s];
			for (int k = 0; k < SPS; k++) begin
				if (s * SPS + k < W) begin
					t  = {r, q[W-1]};
					ge = (t >= d);
					t  = ge ? (t - d) : t;
					r  = t[DW-1:0];
					q  = {q[W-2:0], ge};
				end
			end
			rnx[s] = r;
			qnx[s] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NST; s++) v_s[s] <= 1'b0;
		end else if (en) begin
			v_s <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rnx;
			dq_s  <= qnx;
			tag_s <= tin;
		end
	end

	assign out_vld = v_s[NST-1];
	assign quot    = dq_s[NST-1];
	assign rem     = rem_s[NST-1];
	assign out_tag = tag_s[NST-1];

endmodule

`default_nettype wire

// ----- hw/rtl/ata_taskfile_command_builder_top.sv -----
// ----------------------------------------------------------------------------
// ata_taskfile_command_builder_top: ATA task-file command builder
// checks a sector request and emits its ordered task-file register writes
// ----------------------------------------------------------------------------
// order: request capture, limit check, error priority, track and cylinder
//   dividers, then the serializer registers
// throughput: one result per cycle while out_ready is high; a request gives
//   1, 6 or 10 writes; in_ready is low until the serializer's last write goes
// reset: arst_n clears all valid bits and the serializer, config goes to
//   mode 0, total 0, multiple limit 1, geometry 1/1
`default_nettype none

module ata_taskfile_command_builder_top
	import atb_pkg::*;
#(
	parameter int DIV_STEPS = ATB_DIV_STEPS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire atb_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output atb_out_t                  out_data,
	input  wire logic                 cfg_we,
	input  wire logic [ATB_IDX_W-1:0] cfg_index,
	input  wire logic [ATB_CFG_W-1:0] cfg_data
);

	// config registers
	logic [1:0]           mode_q;
	logic [ATB_LBA_W-1:0] total_q;
	logic [7:0]           maxs_q;
	logic [ATB_GEO_W-1:0] spt_q;
	logic [ATB_GEO_W-1:0] heads_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CHS;
			total_q <= '0;
			maxs_q  <= 8'd1;
			spt_q   <= ATB_GEO_W'(1);
			heads_q <= ATB_GEO_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[1:0];
				CFG_TOTAL: total_q <= cfg_data[ATB_LBA_W-1:0];
				CFG_MAXS:  maxs_q  <= cfg_data[7:0];
				CFG_SPT:   spt_q   <= cfg_data[ATB_GEO_W-1:0];
				CFG_HEADS: heads_q <= cfg_data[ATB_GEO_W-1:0];
				default: ;
			endcase
		end
	end

	// zero geometry counts act as one
	logic [ATB_GEO_W-1:0] spt_div, heads_div;
	assign spt_div   = (spt_q == '0) ? ATB_GEO_W'(1) : spt_q;
	assign heads_div = (heads_q == '0) ? ATB_GEO_W'(1) : heads_q;

	// whole pipeline advances together; the serializer holds it while busy
	logic en;

	// stage 1: request capture
	logic    v_s1;
	atb_in_t req_s1;

	// stage 2: request end and multiple-limit check
	logic                 v_s2;
	atb_in_t              req_s2;
	logic [ATB_LBA_W:0]   end_s2;
	logic                 over_s2;

	// stage 3: error priority and address mode
	logic      v_s3;
	atb_item_t item_s3;

	atb_item_t item_c;
	always_comb begin
		logic big;
		big = (end_s2 > LBA28_LIMIT);
		item_c.func         = req_s2.func;
		item_c.start_sector = req_s2.start_sector;
		item_c.sector_count = req_s2.sector_count;
		item_c.big          = big;
		item_c.lba          = (mode_q != MODE_CHS);
		priority if (over_s2)                                item_c.err = ERR_MULTIPLE;
		else if (end_s2 > {1'b0, total_q})                   item_c.err = ERR_PAST_END;
		else if (mode_q != MODE_LBA48 && big)                item_c.err = ERR_NO_LBA48;
		else if (!big && req_s2.sector_count[ATB_CNT_W-1:8] != '0) item_c.err = ERR_COUNT;
		else                                                 item_c.err = ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= in_data;
			req_s2  <= req_s1;
			end_s2  <= {1'b0, req_s1.start_sector} + (ATB_LBA_W+1)'(req_s1.sector_count);
			over_s2 <= (req_s1.sector_count > ATB_CNT_W'(maxs_q));
			item_s3 <= item_c;
		end
	end

	assign in_ready = en;

	// chs: track and sector from start / spt, then head and cylinder
	logic                 d1_vld;
	logic [ATB_LBA_W-1:0] d1_quot;
	logic [ATB_GEO_W-1:0] d1_rem;
	logic [$bits(atb_item_t)-1:0] d1_tag;

	atb_div #(
		.W(ATB_LBA_W), .DW(ATB_GEO_W), .SPS(DIV_STEPS), .TW($bits(atb_item_t))
	) u_div_track (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s3), .dividend(item_s3.start_sector), .divisor(spt_div),
		.in_tag(item_s3),
		.out_vld(d1_vld), .quot(d1_quot), .rem(d1_rem), .out_tag(d1_tag)
	);

	atb_div2_tag_t d2_in_tag, d2_tag;
	logic                 d2_vld;
	logic [ATB_LBA_W-1:0] d2_quot;
	logic [ATB_GEO_W-1:0] d2_rem;
	logic [$bits(atb_div2_tag_t)-1:0] d2_tag_bits;

	assign d2_in_tag.item     = atb_item_t'(d1_tag);
	assign d2_in_tag.sect_rem = d1_rem;
	assign d2_tag             = atb_div2_tag_t'(d2_tag_bits);

	atb_div #(
		.W(ATB_LBA_W), .DW(ATB_GEO_W), .SPS(DIV_STEPS), .TW($bits(atb_div2_tag_t))
	) u_div_cyl (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(d1_vld), .dividend(d1_quot), .divisor(heads_div),
		.in_tag(d2_in_tag),
		.out_vld(d2_vld), .quot(d2_quot), .rem(d2_rem), .out_tag(d2_tag_bits)
	);

	// serializer: one register write per transfer
	logic       busy_q;
	logic [3:0] idx_q;
	atb_item_t  cur_q;
	logic [7:0] sect_q;
	logic [7:0] head_q;
	logic [15:0] cyl_q;

	function automatic atb_out_t result(atb_item_t it, logic [7:0] sect, logic [7:0] head,
			logic [15:0] cyl, logic [3:0] idx);
		atb_out_t   o;
		logic [7:0] cmd;
		logic       mult;
		mult = (it.sector_count > ATB_CNT_W'(1));
		if (it.func) cmd = mult ? (it.big ? CMD_WR_MULT_EXT : CMD_WR_MULT)
		                        : (it.big ? CMD_WR_SECT_EXT : CMD_WR_SECT);
		else         cmd = mult ? (it.big ? CMD_RD_MULT_EXT : CMD_RD_MULT)
		                        : (it.big ? CMD_RD_SECT_EXT : CMD_RD_SECT);
		o.error_code = ERR_NONE;
		o.last       = 1'b0;
		if (it.err != ERR_NONE) begin
			o.reg_addr   = REG_CMD;
			o.reg_value  = 8'h00;
			o.error_code = it.err;
			o.last       = 1'b1;
		end else if (it.big) begin
			// high bytes pass first, then low bytes
			case (idx)
				4'd0: begin o.reg_addr = REG_SEL;   o.reg_value = SEL_LBA48; end
				4'd1: begin o.reg_addr = REG_COUNT; o.reg_value = it.sector_count[15:8]; end
				4'd2: begin o.reg_addr = REG_LBA0;  o.reg_value = it.start_sector[31:24]; end
				4'd3: begin o.reg_addr = REG_LBA1;  o.reg_value = it.start_sector[39:32]; end
				4'd4: begin o.reg_addr = REG_LBA2;  o.reg_value = it.start_sector[47:40]; end
				4'd5: begin o.reg_addr = REG_COUNT; o.reg_value = it.sector_count[7:0]; end
				4'd6: begin o.reg_addr = REG_LBA0;  o.reg_value = it.start_sector[7:0]; end
				4'd7: begin o.reg_addr = REG_LBA1;  o.reg_value = it.start_sector[15:8]; end
				4'd8: begin o.reg_addr = REG_LBA2;  o.reg_value = it.start_sector[23:16]; end
				default: begin o.reg_addr = REG_CMD; o.reg_value = cmd; o.last = 1'b1; end
			endcase
		end else begin
			case (idx)
				4'd0: begin
					o.reg_addr  = REG_SEL;
					o.reg_value = it.lba ? (SEL_LBA28 | {4'h0, it.start_sector[27:24]}) : head;
				end
				4'd1: begin o.reg_addr = REG_COUNT; o.reg_value = it.sector_count[7:0]; end
				4'd2: begin
					o.reg_addr  = REG_LBA0;
					o.reg_value = it.lba ? it.start_sector[7:0] : sect;
				end
				4'd3: begin
					o.reg_addr  = REG_LBA1;
					o.reg_value = it.lba ? it.start_sector[15:8] : cyl[7:0];
				end
				4'd4: begin
					o.reg_addr  = REG_LBA2;
					o.reg_value = it.lba ? it.start_sector[23:16] : cyl[15:8];
				end
				default: begin o.reg_addr = REG_CMD; o.reg_value = cmd; o.last = 1'b1; end
			endcase
		end
		return o;
	endfunction

	assign out_data  = result(cur_q, sect_q, head_q, cyl_q, idx_q);
	assign out_valid = busy_q;

	logic fin;
	assign fin = busy_q && out_ready && out_data.last;
	assign en  = !busy_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (en) begin
			busy_q <= d2_vld;
			idx_q  <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// sector number is one-based
	logic [ATB_GEO_W-1:0] sect_one;
	assign sect_one = d2_tag.sect_rem + ATB_GEO_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			cur_q  <= d2_tag.item;
			sect_q <= sect_one[7:0];
			head_q <= d2_rem[7:0];
			cyl_q  <= d2_quot[15:0];
		end
	end

	// write index never runs past the command byte
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= 4'd9))
		else $error("result index out of range");

	// an error request gives exactly one result
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cur_q.err != ERR_NONE) |-> (out_data.last && idx_q == 4'd0))
		else $error("error result not single");

	// a short request never reaches the extended-only indexes
	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !cur_q.big) |-> (idx_q <= 4'd5))
		else $error("short request ran too long");

	// finishing with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && !d2_vld) |=> !out_valid)
		else $error("output stayed valid after last transfer");

endmodule

`default_nettype wire
